[design/aavr_pkg.sv]
// Shared types, constants and tables for the axis-angle vertex rotator.
package aavr_pkg;

  localparam int CordicSteps = 28;
  localparam logic signed [33:0] PiQ28     = 34'sd843314857;
  localparam logic signed [33:0] TwoPiQ28  = 34'sd1686629713;
  localparam logic signed [33:0] HalfPiQ28 = 34'sd421657428;
  localparam logic signed [33:0] CordicGain = 34'sd652032874;
  localparam logic signed [31:0] OneQ30 = 32'sd1073741824;

  typedef enum logic [1:0] {
    REG_AXIS_X = 2'd0,
    REG_AXIS_Y = 2'd1,
    REG_AXIS_Z = 2'd2,
    REG_ANGLE  = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    BLD_IDLE,
    BLD_NORM,
    BLD_SQRT,
    BLD_DIV,
    BLD_CORDIC,
    BLD_MAT,
    BLD_DONE
  } bld_state_t;

  typedef logic signed [31:0] coef_t;

  // matrix and flag handed from the builder to the datapath
  typedef struct packed {
    coef_t [8:0] m;
    logic        zero_axis;
  } mat_bus_t;

  function automatic logic [31:0] atan_q30(input logic [4:0] i);
    logic [31:0] v;
    unique case (i)
      5'd0: v = 32'h3243F6A8;   5'd1: v = 32'h1DAC6705;
      5'd2: v = 32'h0FADBAFC;   5'd3: v = 32'h07F56EA6;
      5'd4: v = 32'h03FEAB76;   5'd5: v = 32'h01FFD55B;
      5'd6: v = 32'h00FFFAAA;   5'd7: v = 32'h007FFF55;
      5'd8: v = 32'h003FFFEA;   5'd9: v = 32'h001FFFFD;
      5'd10: v = 32'h000FFFFF;  5'd11: v = 32'h0007FFFF;
      5'd12: v = 32'h0003FFFF;  5'd13: v = 32'h0001FFFF;
      5'd14: v = 32'h0000FFFF;  5'd15: v = 32'h00007FFF;
      5'd16: v = 32'h00003FFF;  5'd17: v = 32'h00001FFF;
      5'd18: v = 32'h00000FFF;  5'd19: v = 32'h000007FF;
      5'd20: v = 32'h000003FF;  5'd21: v = 32'h000001FF;
      5'd22: v = 32'h000000FF;  5'd23: v = 32'h0000007F;
      5'd24: v = 32'h0000003F;  5'd25: v = 32'h0000001F;
      5'd26: v = 32'h0000000F;  5'd27: v = 32'h00000007;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

endpackage

[design/aavr_builder.sv]
// Sequential matrix builder: normalize, square root, divide, CORDIC, products.
module aavr_builder (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [31:0]      axis_x,
  input  logic signed [31:0]      axis_y,
  input  logic signed [31:0]      axis_z,
  input  logic signed [31:0]      angle,
  output logic                    busy,
  output logic                    done,
  output aavr_pkg::mat_bus_t      mat
);
  import aavr_pkg::*;

  bld_state_t state_r, state_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [31:0] sh_r [3];
  logic [31:0] sh_nxt [3];
  logic [2:0]  neg_r;
  logic [63:0] sq_r, sq_nxt;
  logic [63:0] rem_r, rem_nxt;
  logic [31:0] root_r, root_nxt;
  logic [1:0]  dsel_r, dsel_nxt;
  logic [62:0] dnum_r, dnum_nxt;
  logic [31:0] dq_r, dq_nxt;
  logic [31:0] dr_r, dr_nxt;
  coef_t       u_r [3];
  coef_t       u_nxt [3];
  logic signed [33:0] cx_r, cy_r, cz_r, cx_nxt, cy_nxt, cz_nxt;
  logic        cneg_r, cneg_nxt;
  coef_t       c_r, s_r, c_nxt, s_nxt;
  logic [3:0]  mi_r, mi_nxt;
  logic [1:0]  mph_r, mph_nxt;
  logic signed [32:0] tmp_r, tmp_nxt;
  logic signed [63:0] prod_r, prod_nxt;
  mat_bus_t    mat_r, mat_nxt;

  logic [31:0] mag [3];
  logic [31:0] mmax;
  logic [5:0]  lz;
  logic [5:0]  nsh;
  logic signed [33:0] a1, a2;
  logic [63:0] trial;
  logic [32:0] dtrial;
  logic [33:0] xs, ys;
  logic signed [31:0] pa;
  logic signed [32:0] pb;
  logic signed [32:0] qres;
  logic [1:0]  ri, ci;
  logic signed [32:0] cterm;

  function automatic logic signed [31:0] clamp_q30(input logic signed [34:0] v);
    if (v > 35'sd1073741824) return OneQ30;
    if (v < -35'sd1073741824) return -OneQ30;
    return v[31:0];
  endfunction

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic signed [31:0] c;
      c = (i == 0) ? axis_x : ((i == 1) ? axis_y : axis_z);
      mag[i] = c[31] ? (~c + 32'd1) : c;
    end
    mmax = mag[0];
    if (mag[1] > mmax) mmax = mag[1];
    if (mag[2] > mmax) mmax = mag[2];
    lz = 6'd0;
    for (int b = 31; b >= 0; b--) begin
      if (mmax[b] == 1'b0 && lz == 6'(31 - b)) lz = lz + 6'd1;
    end
    // a power of two goes all the way up to 2^31
    nsh = ((mmax & (mmax - 32'd1)) == 32'd0) ? lz : (lz - 6'd1);
  end

  // q30 rounding of the registered product
  assign qres = 33'(($signed(prod_r) + 64'sd536870912) >>> 30);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    sh_nxt = sh_r;
    sq_nxt = sq_r;
    rem_nxt = rem_r;
    root_nxt = root_r;
    dsel_nxt = dsel_r;
    dnum_nxt = dnum_r;
    dq_nxt = dq_r;
    dr_nxt = dr_r;
    u_nxt = u_r;
    cx_nxt = cx_r; cy_nxt = cy_r; cz_nxt = cz_r;
    cneg_nxt = cneg_r;
    c_nxt = c_r; s_nxt = s_r;
    mi_nxt = mi_r; mph_nxt = mph_r;
    tmp_nxt = tmp_r;
    prod_nxt = prod_r;
    mat_nxt = mat_r;
    done = 1'b0;
    a1 = '0; a2 = '0; trial = '0; dtrial = '0; xs = '0; ys = '0;
    pa = '0; pb = '0; ri = '0; ci = '0; cterm = '0;
    unique case (state_r)
      BLD_IDLE: begin
        if (start) begin
          if (axis_x == 0 && axis_y == 0 && axis_z == 0) begin
            for (int i = 0; i < 9; i++) mat_nxt.m[i] = (i % 4 == 0) ? OneQ30 : '0;
            mat_nxt.zero_axis = 1'b1;
            state_nxt = BLD_DONE;
          end else begin
            // top magnitude lands in (2^30, 2^31]
            for (int i = 0; i < 3; i++)
              sh_nxt[i] = mag[i] << nsh;
            sq_nxt = '0;
            cnt_nxt = '0;
            state_nxt = BLD_NORM;
          end
        end
      end
      BLD_NORM: begin
        sq_nxt = sq_r + 64'(sh_r[cnt_r[1:0]]) * 64'(sh_r[cnt_r[1:0]]);
        if (cnt_r == 6'd2) begin
          cnt_nxt = 6'd31;
          rem_nxt = sq_r + 64'(sh_r[2]) * 64'(sh_r[2]);
          root_nxt = '0;
          state_nxt = BLD_SQRT;
        end else cnt_nxt = cnt_r + 6'd1;
      end
      BLD_SQRT: begin
        // restoring root, one bit per cycle
        trial = (64'(root_r) << (6'(cnt_r[4:0]) + 6'd1)) + (64'd1 << (2 * cnt_r[4:0]));
        if (rem_r >= trial) begin
          rem_nxt = rem_r - trial;
          root_nxt = root_r | (32'd1 << cnt_r[4:0]);
        end
        if (cnt_r == 6'd0) begin
          dsel_nxt = '0;
          dnum_nxt = {1'b0, sh_r[0], 30'd0} + 63'(root_nxt >> 1);
          dq_nxt = '0; dr_nxt = '0;
          cnt_nxt = 6'd62;
          state_nxt = BLD_DIV;
        end else cnt_nxt = cnt_r - 6'd1;
      end
      BLD_DIV: begin
        // (sh<<30 + len/2) / len, quotient fits 31 bits; bit-serial
        dtrial = {dr_r, dnum_r[cnt_r]};
        if (dtrial >= 33'(root_r)) begin
          dr_nxt = 32'(dtrial - 33'(root_r));
          dq_nxt = {dq_r[30:0], 1'b1};
        end else begin
          dr_nxt = dtrial[31:0];
          dq_nxt = {dq_r[30:0], 1'b0};
        end
        if (cnt_r == 6'd0) begin
          u_nxt[dsel_r] = neg_r[dsel_r] ? -dq_nxt : dq_nxt;
          dq_nxt = '0; dr_nxt = '0;
          cnt_nxt = 6'd62;
          if (dsel_r == 2'd2) begin
            a1 = {{2{angle[31]}}, angle};
            if (a1 > PiQ28) a1 = a1 - TwoPiQ28;
            else if (a1 < -PiQ28) a1 = a1 + TwoPiQ28;
            cneg_nxt = 1'b0;
            if (a1 > HalfPiQ28) begin a1 = a1 - PiQ28; cneg_nxt = 1'b1; end
            else if (a1 < -HalfPiQ28) begin a1 = a1 + PiQ28; cneg_nxt = 1'b1; end
            cz_nxt = a1 <<< 2;
            cx_nxt = CordicGain; cy_nxt = '0;
            cnt_nxt = '0;
            state_nxt = BLD_CORDIC;
          end else begin
            dsel_nxt = dsel_r + 2'd1;
            dnum_nxt = {1'b0, sh_r[dsel_r + 2'd1], 30'd0} + 63'(root_r >> 1);
          end
        end else cnt_nxt = cnt_r - 6'd1;
      end
      BLD_CORDIC: begin
        xs = 34'(cx_r >>> cnt_r[4:0]);
        ys = 34'(cy_r >>> cnt_r[4:0]);
        if (!cz_r[33]) begin
          cx_nxt = cx_r - $signed(ys); cy_nxt = cy_r + $signed(xs);
          cz_nxt = cz_r - $signed({2'b00, atan_q30(cnt_r[4:0])});
        end else begin
          cx_nxt = cx_r + $signed(ys); cy_nxt = cy_r - $signed(xs);
          cz_nxt = cz_r + $signed({2'b00, atan_q30(cnt_r[4:0])});
        end
        if (cnt_r == 6'(CordicSteps - 1)) begin
          a1 = cneg_r ? -cx_nxt : cx_nxt;
          a2 = cneg_r ? -cy_nxt : cy_nxt;
          c_nxt = clamp_q30(35'(a1));
          s_nxt = clamp_q30(35'(a2));
          mi_nxt = '0; mph_nxt = '0;
          state_nxt = BLD_MAT;
        end else cnt_nxt = cnt_r + 6'd1;
      end
      BLD_MAT: begin
        // per coefficient: p=ui*uj, p=q(p)*t, p=uk*s, combine
        ri = (mi_r < 4'd3) ? 2'd0 : ((mi_r < 4'd6) ? 2'd1 : 2'd2);
        ci = 2'(mi_r - 4'(ri) * 4'd3);
        unique case (mph_r)
          2'd0: begin pa = u_r[ri]; pb = 33'(u_r[ci]); end
          // t = 1 - cos reaches 2^31 at cos = -1
          2'd1: begin pa = 32'(qres); pb = 33'(OneQ30) - 33'(c_r); end
          2'd2: begin
            tmp_nxt = qres;
            pa = (ri == ci) ? '0 : u_r[2'd3 - ri - ci];
            pb = 33'(s_r);
          end
          default: begin pa = '0; pb = '0; end
        endcase
        prod_nxt = 64'(pa) * 64'(pb);
        if (mph_r == 2'd3) begin
          // off-diagonal sign from Rodrigues cross term
          if (ri == ci) cterm = 33'(c_r);
          else if ((ri == 2'd0 && ci == 2'd1) || (ri == 2'd1 && ci == 2'd2)
                   || (ri == 2'd2 && ci == 2'd0)) cterm = -qres;
          else cterm = qres;
          mat_nxt.m[mi_r] = clamp_q30(35'(tmp_r) + 35'(cterm));
          mph_nxt = '0;
          if (mi_r == 4'd8) begin
            mat_nxt.zero_axis = 1'b0;
            state_nxt = BLD_DONE;
          end else mi_nxt = mi_r + 4'd1;
        end else mph_nxt = mph_r + 2'd1;
      end
      BLD_DONE: begin
        done = 1'b1;
        state_nxt = BLD_IDLE;
      end
      default: state_nxt = BLD_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BLD_IDLE;
      for (int i = 0; i < 9; i++) mat_r.m[i] <= (i % 4 == 0) ? OneQ30 : '0;
      mat_r.zero_axis <= 1'b0;
    end else begin
      state_r <= state_nxt;
      mat_r <= mat_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    sh_r <= sh_nxt;
    if (state_r == BLD_IDLE) neg_r <= {axis_z[31], axis_y[31], axis_x[31]};
    sq_r <= sq_nxt; rem_r <= rem_nxt; root_r <= root_nxt;
    dsel_r <= dsel_nxt; dnum_r <= dnum_nxt; dq_r <= dq_nxt; dr_r <= dr_nxt;
    u_r <= u_nxt;
    cx_r <= cx_nxt; cy_r <= cy_nxt; cz_r <= cz_nxt; cneg_r <= cneg_nxt;
    c_r <= c_nxt; s_r <= s_nxt;
    mi_r <= mi_nxt; mph_r <= mph_nxt; tmp_r <= tmp_nxt; prod_r <= prod_nxt;
  end

  assign busy = (state_r != BLD_IDLE);
  assign mat = mat_r;

`ifndef SYNTHESIS
  a_done_once: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> !done) else $error("builder done held");
  a_zero_id: assert property (@(posedge clk) disable iff (!rst_n)
    done && mat_r.zero_axis |-> mat_r.m[0] == OneQ30 && mat_r.m[1] == 0)
    else $error("zero axis without identity");
  a_coef_range: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> mat_r.m[4] <= OneQ30 && mat_r.m[4] >= -OneQ30)
    else $error("coefficient out of range");
`endif

endmodule

[design/axis_angle_vertex_rotator.sv]
// Top level: config registers, matrix builder and a four-stage vertex datapath.
// After reset or any configuration write, the first vertex waits while the
// matrix is rebuilt by a sequential unit (a bit-serial square root, three
// 63-step bit-serial divides, a 28-step CORDIC and 36 multiply steps). With
// the matrix held, one vertex enters per cycle and its result passes through
// the input, product, sum and rounding registers to the output; a stalled
// output holds the whole pipeline.
module axis_angle_vertex_rotator (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // pos_x, pos_y, pos_z, attr_a, attr_b, attr_c
  input  logic [191:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // rot_x, rot_y, rot_z, out_attr_a, out_attr_b, out_attr_c
  output logic [191:0] out_tdata,
  // axis_invalid
  output logic         out_tuser,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data
);
  import aavr_pkg::*;

  logic signed [31:0] ax_r, ay_r, az_r, ang_r;
  logic stale_r;
  logic bld_start, bld_busy, bld_done;
  mat_bus_t mat;

  logic adv;
  logic [3:0] v_r;
  logic signed [31:0] p_r [3];
  logic [95:0] at1_r, at2_r, at3_r, at4_r;
  logic signed [63:0] pr_r [9];
  logic signed [65:0] sum_r [3];
  logic [95:0] res_r;
  logic zf_r [4];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ax_r <= '0; ay_r <= 32'sd65536; az_r <= '0; ang_r <= '0;
      stale_r <= 1'b1;
    end else begin
      if (cfg_valid) begin
        unique case (reg_idx_t'(cfg_index))
          REG_AXIS_X: ax_r <= cfg_data;
          REG_AXIS_Y: ay_r <= cfg_data;
          REG_AXIS_Z: az_r <= cfg_data;
          REG_ANGLE:  ang_r <= cfg_data;
          default: ;
        endcase
        stale_r <= 1'b1;
      end else if (bld_start) stale_r <= 1'b0;
    end
  end

  assign bld_start = stale_r && in_tvalid && !bld_busy && !cfg_valid;

  aavr_builder u_bld (
    .clk(clk), .rst_n(rst_n), .start(bld_start),
    .axis_x(ax_r), .axis_y(ay_r), .axis_z(az_r), .angle(ang_r),
    .busy(bld_busy), .done(bld_done), .mat(mat)
  );

  // whole pipe stalls together on output backpressure
  assign adv = !v_r[3] || out_tready;
  assign in_tready = adv && !stale_r && !bld_busy;

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else if (adv) v_r <= {v_r[2:0], in_tvalid && in_tready};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) p_r[i] <= in_tdata[32*i +: 32];
      at1_r <= in_tdata[191:96];
      zf_r[0] <= mat.zero_axis;
      for (int i = 0; i < 9; i++) pr_r[i] <= 64'(mat.m[i]) * 64'(p_r[i % 3]);
      at2_r <= at1_r; zf_r[1] <= zf_r[0];
      for (int r = 0; r < 3; r++)
        sum_r[r] <= 66'(pr_r[3*r]) + 66'(pr_r[3*r+1]) + 66'(pr_r[3*r+2])
                    + 66'sd536870912;
      at3_r <= at2_r; zf_r[2] <= zf_r[1];
      for (int r = 0; r < 3; r++) begin
        logic signed [35:0] q;
        q = 36'(sum_r[r] >>> 30);
        if (q > 36'sd2147483647) res_r[32*r +: 32] <= 32'h7FFF_FFFF;
        else if (q < -36'sd2147483648) res_r[32*r +: 32] <= 32'h8000_0000;
        else res_r[32*r +: 32] <= q[31:0];
      end
      at4_r <= at3_r; zf_r[3] <= zf_r[2];
    end
  end

  assign out_tvalid = v_r[3];
  assign out_tdata = {at4_r, res_r};
  assign out_tuser = zf_r[3];

`ifndef SYNTHESIS
  a_no_accept_stale: assert property (@(posedge clk) disable iff (!rst_n)
    stale_r |-> !(in_tvalid && in_tready)) else $error("item taken with stale matrix");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");
  a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
    bld_start |=> bld_busy) else $error("builder did not start");
`endif

endmodule
